[rtl/core/dcpn_pkg.sv]
// Shared constants, status codes and interface structs of the DC removal
// and peak normaliser. No dependencies.
`timescale 1ns / 1ps

package dcpn_pkg;

  localparam int DEPTH     = 4096;
  localparam int FRAC_BITS = 15;

  localparam int SMP_W   = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int SUM_W   = SMP_W + ADDR_W;
  localparam int PEAK_W  = SMP_W + 1;
  localparam int NORM_W  = 16;
  localparam int STEP_W  = $clog2(SUM_W + 1);
  localparam int QR_W    = FRAC_BITS + 2;

  localparam logic [PEAK_W-1:0] NORM_POS_LIM = PEAK_W'(32767);
  localparam logic [PEAK_W-1:0] NORM_NEG_LIM = PEAK_W'(32768);

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef struct packed {
    logic                     wr_en;
    logic                     restart;
    logic signed [SMP_W-1:0]  wr_sample;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
  } store_req_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]         count;
    logic signed [SMP_W-1:0]  min_val;
    logic signed [SMP_W-1:0]  max_val;
  } store_stats_t;

  typedef struct packed {
    logic                     start;
    logic [SUM_W-1:0]         dividend;
    logic [PEAK_W-1:0]        rem_init;
    logic [PEAK_W-1:0]        divisor;
    logic [STEP_W-1:0]        steps;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic [SUM_W-1:0]         quo;
  } div_rsp_t;

endpackage

[rtl/core/dcpn_divider.sv]
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on dcpn_pkg.
`timescale 1ns / 1ps

module dcpn_divider (
  input  logic                clk,
  input  logic                rst,
  input  dcpn_pkg::div_req_t  req,
  output dcpn_pkg::div_rsp_t  rsp
);
  import dcpn_pkg::*;

  logic                running;
  logic [STEP_W-1:0]   cnt;
  logic [SUM_W-1:0]    acc;
  logic [PEAK_W-1:0]   rem;
  logic [PEAK_W-1:0]   den;
  logic                done;

  logic [PEAK_W:0]     rem_sh;
  logic [PEAK_W:0]     trial;

  // shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem, acc[SUM_W-1]};
    trial  = rem_sh - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt     <= req.steps;
        acc     <= req.dividend;
        rem     <= req.rem_init;
        den     <= req.divisor;
      end else if (running) begin
        if (!trial[PEAK_W]) begin
          rem <= trial[PEAK_W-1:0];
          acc <= {acc[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh[PEAK_W-1:0];
          acc <= {acc[SUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == STEP_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = acc;

endmodule

[rtl/core/dcpn_trace_store.sv]
// Trace sample memory with registered read, plus running sum,
// count, minimum and maximum of the loaded trace. Depends on dcpn_pkg.
`timescale 1ns / 1ps

module dcpn_trace_store (
  input  logic                    clk,
  input  logic                    rst,
  input  dcpn_pkg::store_req_t    req,
  output logic signed [dcpn_pkg::SMP_W-1:0] rd_data,
  output dcpn_pkg::store_stats_t  stats
);
  import dcpn_pkg::*;

  logic [SMP_W-1:0] mem [DEPTH];

  logic signed [SUM_W-1:0] sum;
  logic [CNT_W-1:0]        count;
  logic signed [SMP_W-1:0] min_val;
  logic signed [SMP_W-1:0] max_val;

  logic [CNT_W-1:0]        eff_count;
  logic signed [SUM_W-1:0] base_sum;
  logic                    first;

  // a restart drops the old trace before this sample goes in
  always_comb begin
    eff_count = req.restart ? '0 : count;
    base_sum  = req.restart ? '0 : sum;
    first     = (eff_count == '0);
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[eff_count[ADDR_W-1:0]] <= req.wr_sample;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      count   <= '0;
      min_val <= '0;
      max_val <= '0;
    end else if (req.wr_en) begin
      sum   <= base_sum + SUM_W'(req.wr_sample);
      count <= eff_count + 1'b1;
      if (first || req.wr_sample < min_val) begin
        min_val <= req.wr_sample;
      end
      if (first || req.wr_sample > max_val) begin
        max_val <= req.wr_sample;
      end
    end
  end

  assign stats.sum     = sum;
  assign stats.count   = count;
  assign stats.min_val = min_val;
  assign stats.max_val = max_val;

endmodule

[rtl/core/dc_removal_peak_normalizer.sv]
// Top level of the DC removal and peak normaliser: command sequencer,
// scaling setup and result formatting. Depends on dcpn_pkg,
// dcpn_trace_store and dcpn_divider.
`timescale 1ns / 1ps
//
//  channel   ports                                   transfer when
//  -------   -------------------------------------   -------------------------
//  command   start, busy, func, sample_in            start high, busy low
//  result    done, norm_value, final_flag, status    done high (one cycle)
//
//  A load leaves busy low and the next command may follow at once. A dropped
//  load (store full) reports status 2 in the next cycle. A fetch of a stored
//  sample runs through DIFF_CALC, FRAC_LOAD and FRAC_WAIT up to its result
//  strobe, busy high until then, the shared one-bit-per-cycle divider working
//  out the fractional quotient; with a zero peak the result comes straight
//  from DIFF_CALC. The first fetch of a trace also passes MEAN_LOAD, MEAN_WAIT
//  and PEAK_SET for the rounded mean division on the same divider and the
//  peak. A fetch with nothing to give reports status 1 in the next cycle.
//  rst is synchronous and clears the trace; the result side cannot stall.

module dc_removal_peak_normalizer (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 func,
  input  logic signed [dcpn_pkg::SMP_W-1:0]    sample_in,
  output logic                                 done,
  output logic signed [dcpn_pkg::NORM_W-1:0]   norm_value,
  output logic                                 final_flag,
  output logic [1:0]                           status
);
  import dcpn_pkg::*;

  typedef enum logic [2:0] {
    IDLE,
    MEAN_LOAD,
    MEAN_WAIT,
    PEAK_SET,
    DIFF_CALC,
    FRAC_LOAD,
    FRAC_WAIT
  } state_t;

  state_t state;

  // trace and scaling state
  logic                     fetch_phase;
  logic [CNT_W-1:0]         read_pointer;
  logic signed [SMP_W-1:0]  mean_value;
  logic [PEAK_W-1:0]        peak_value;
  logic                     sum_neg;
  logic [PEAK_W-1:0]        d_mag;
  logic                     d_neg;
  logic                     frac_top;

  store_req_t               store_req;
  store_stats_t             stats;
  logic signed [SMP_W-1:0]  rd_data;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic                     accept;
  logic                     load_cmd;
  logic                     fetch_cmd;
  logic                     store_full;
  logic                     have_next;
  logic                     is_final;

  logic [SUM_W-1:0]         sum_mag;
  logic [SUM_W-1:0]         mean_dividend;
  logic signed [PEAK_W-1:0] up_diff;
  logic signed [PEAK_W-1:0] dn_diff;
  logic [PEAK_W-1:0]        up_clamp;
  logic [PEAK_W-1:0]        dn_clamp;
  logic [PEAK_W-1:0]        peak_calc;
  logic signed [PEAK_W-1:0] d_val;
  logic                     mag_ge;
  logic [QR_W-1:0]          q2;
  logic [QR_W-1:0]          q2_round;
  logic [PEAK_W-1:0]        q_ext;
  logic [PEAK_W-1:0]        q_sat;
  logic [NORM_W-1:0]        norm_calc;

  dcpn_trace_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (rd_data),
    .stats   (stats)
  );

  dcpn_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign busy = (state != IDLE);

  always_comb begin
    accept     = start && !busy;
    load_cmd   = accept && (func == FUNC_LOAD);
    fetch_cmd  = accept && (func == FUNC_FETCH);
    store_full = (stats.count >= CNT_W'(DEPTH));
    have_next  = (read_pointer < stats.count);
    is_final   = ((read_pointer + 1'b1) == stats.count);

    // a load after fetching begins a new trace, so it is never dropped
    store_req.wr_en     = load_cmd && (fetch_phase || !store_full);
    store_req.restart   = fetch_phase;
    store_req.wr_sample = sample_in;
    store_req.rd_en     = (fetch_cmd && fetch_phase && have_next) || (state == PEAK_SET);
    store_req.rd_addr   = read_pointer[ADDR_W-1:0];

    // rounded mean: (|sum| + count/2) / count, sign put back afterwards
    sum_mag       = stats.sum[SUM_W-1] ? SUM_W'(-stats.sum) : SUM_W'(stats.sum);
    mean_dividend = sum_mag + SUM_W'(stats.count >> 1);

    // peak: the larger excursion from the mean, never negative
    up_diff   = {stats.max_val[SMP_W-1], stats.max_val} - {mean_value[SMP_W-1], mean_value};
    dn_diff   = {mean_value[SMP_W-1], mean_value} - {stats.min_val[SMP_W-1], stats.min_val};
    up_clamp  = up_diff[PEAK_W-1] ? '0 : up_diff;
    dn_clamp  = dn_diff[PEAK_W-1] ? '0 : dn_diff;
    peak_calc = (up_clamp > dn_clamp) ? up_clamp : dn_clamp;

    d_val  = {rd_data[SMP_W-1], rd_data} - {mean_value[SMP_W-1], mean_value};
    mag_ge = (d_mag >= peak_value);

    // divider runs for the mean, or for FRAC_BITS+1 fraction bits of |d|/peak
    div_req.start = (state == MEAN_LOAD) || (state == FRAC_LOAD);
    if (state == MEAN_LOAD) begin
      div_req.dividend = mean_dividend;
      div_req.rem_init = '0;
      div_req.divisor  = PEAK_W'(stats.count);
      div_req.steps    = STEP_W'(SUM_W);
    end else begin
      div_req.dividend = '0;
      div_req.rem_init = mag_ge ? (d_mag - peak_value) : d_mag;
      div_req.divisor  = peak_value;
      div_req.steps    = STEP_W'(FRAC_BITS + 1);
    end

    // extra quotient bit rounds to nearest, ties away from zero
    q2       = {frac_top, div_rsp.quo[FRAC_BITS:0]};
    q2_round = (q2 + 1'b1) >> 1;
    q_ext    = PEAK_W'(q2_round);
    if (d_neg) begin
      q_sat     = (q_ext > NORM_NEG_LIM) ? NORM_NEG_LIM : q_ext;
      norm_calc = NORM_W'(-q_sat);
    end else begin
      q_sat     = (q_ext > NORM_POS_LIM) ? NORM_POS_LIM : q_ext;
      norm_calc = NORM_W'(q_sat);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      fetch_phase  <= 1'b0;
      read_pointer <= '0;
      done         <= 1'b0;
      norm_value   <= '0;
      final_flag   <= 1'b0;
      status       <= STATUS_OK;
    end else begin
      done <= 1'b0;
      case (state)
        IDLE: begin
          if (load_cmd) begin
            if (fetch_phase) begin
              fetch_phase  <= 1'b0;
              read_pointer <= '0;
            end else if (store_full) begin
              done       <= 1'b1;
              norm_value <= '0;
              final_flag <= 1'b0;
              status     <= STATUS_OVERFLOW;
            end
          end else if (fetch_cmd) begin
            if (stats.count == '0) begin
              done       <= 1'b1;
              norm_value <= '0;
              final_flag <= 1'b0;
              status     <= STATUS_EMPTY;
            end else if (!fetch_phase) begin
              fetch_phase  <= 1'b1;
              read_pointer <= '0;
              state        <= MEAN_LOAD;
            end else if (have_next) begin
              state <= DIFF_CALC;
            end else begin
              done       <= 1'b1;
              norm_value <= '0;
              final_flag <= 1'b0;
              status     <= STATUS_EMPTY;
            end
          end
        end
        MEAN_LOAD: begin
          sum_neg <= stats.sum[SUM_W-1];
          state   <= MEAN_WAIT;
        end
        MEAN_WAIT: begin
          if (div_rsp.done) begin
            mean_value <= sum_neg ? SMP_W'(-div_rsp.quo[SMP_W-1:0])
                                  : SMP_W'(div_rsp.quo[SMP_W-1:0]);
            state      <= PEAK_SET;
          end
        end
        PEAK_SET: begin
          peak_value <= peak_calc;
          state      <= DIFF_CALC;
        end
        DIFF_CALC: begin
          if (peak_value == '0) begin
            done         <= 1'b1;
            norm_value   <= '0;
            final_flag   <= is_final;
            status       <= STATUS_OK;
            read_pointer <= read_pointer + 1'b1;
            state        <= IDLE;
          end else begin
            d_neg <= d_val[PEAK_W-1];
            d_mag <= d_val[PEAK_W-1] ? PEAK_W'(-d_val) : PEAK_W'(d_val);
            state <= FRAC_LOAD;
          end
        end
        FRAC_LOAD: begin
          frac_top <= mag_ge;
          state    <= FRAC_WAIT;
        end
        FRAC_WAIT: begin
          if (div_rsp.done) begin
            done         <= 1'b1;
            norm_value   <= norm_calc;
            final_flag   <= is_final;
            status       <= STATUS_OK;
            read_pointer <= read_pointer + 1'b1;
            state        <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

[tb/tb_dc_removal_peak_normalizer.sv]
// Self-checking testbench of the DC removal and peak normaliser: directed
// table, full-store overflow pass and random traces against a built-in model.
// Depends on dcpn_pkg and dc_removal_peak_normalizer.
`timescale 1ns / 1ps

module tb_dc_removal_peak_normalizer;
  import dcpn_pkg::*;

  // No transfer on either side for this long means the block has hung.
  // The slowest legal gap is a first fetch.
  localparam int WATCHDOG_LIMIT = 2000;
  // Quiet cycles after the last result, so that a stray strobe is still seen.
  localparam int TAIL_CYCLES    = 100;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int IDLE_PCT       = 36;

  typedef struct packed {
    logic signed [NORM_W-1:0] norm;
    logic                     is_last;
    logic [1:0]               status;
  } norm_result_t;

  typedef struct packed {
    logic                    func;
    logic signed [SMP_W-1:0] sample;
    bit                      typed;
    norm_result_t            result;
  } stim_row_t;

  logic                     clk;
  logic                     rst        = 1'b1;
  logic                     start      = 1'b0;
  logic                     func       = FUNC_LOAD;
  logic signed [SMP_W-1:0]  sample_in  = '0;
  logic                     busy;
  logic                     done;
  logic signed [NORM_W-1:0] norm_value;
  logic                     final_flag;
  logic [1:0]               status;

  dc_removal_peak_normalizer dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .sample_in  (sample_in),
    .done       (done),
    .norm_value (norm_value),
    .final_flag (final_flag),
    .status     (status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Trace model: own copy of the store and the per-trace statistics.
  // ---------------------------------------------------------------------------
  logic signed [SMP_W-1:0] trace_mem [DEPTH];
  longint                  acc_sum   = 0;
  int unsigned             n_loaded  = 0;
  logic signed [SMP_W-1:0] lo_seen   = '0;
  logic signed [SMP_W-1:0] hi_seen   = '0;
  int unsigned             rd_idx    = 0;
  bit                      fetching  = 1'b0;
  longint                  mean_m    = 0;
  longint                  peak_p    = 0;

  norm_result_t pending_results [$];
  int           fail_count   = 0;
  int           stall_cycles = 0;
  bit           steady       = 1'b0;   // no idling while set
  stim_row_t    directed_rows [$];

  // Applies one command to the model; says whether a result follows and
  // what it holds.
  task automatic trace_model_step(input logic f, input logic signed [SMP_W-1:0] s,
                                  output bit produced, output norm_result_t r);
    longint d, mag, q, rem, v, up, dn;
    produced = 1'b0;
    r        = '0;
    r.status = STATUS_OK;
    if (f == FUNC_LOAD) begin
      // a load after fetching opens a new trace
      if (fetching) begin
        acc_sum  = 0;
        n_loaded = 0;
        lo_seen  = '0;
        hi_seen  = '0;
        rd_idx   = 0;
        fetching = 1'b0;
      end
      if (n_loaded >= DEPTH) begin
        produced = 1'b1;
        r.status = STATUS_OVERFLOW;
      end else begin
        trace_mem[n_loaded[ADDR_W-1:0]] = s;
        acc_sum += longint'(s);
        if (n_loaded == 0) begin
          lo_seen = s;
          hi_seen = s;
        end else begin
          if (s < lo_seen) lo_seen = s;
          if (s > hi_seen) hi_seen = s;
        end
        n_loaded++;
      end
    end else begin
      produced = 1'b1;
      if (n_loaded == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        if (!fetching) begin
          // mean rounded half away from zero, peak from the wider side
          mag    = (acc_sum < 0) ? -acc_sum : acc_sum;
          q      = (mag + longint'(n_loaded / 2)) / longint'(n_loaded);
          mean_m = (acc_sum < 0) ? -q : q;
          up     = longint'(hi_seen) - mean_m;
          dn     = mean_m - longint'(lo_seen);
          if (up < 0) up = 0;
          if (dn < 0) dn = 0;
          peak_p   = (up > dn) ? up : dn;
          fetching = 1'b1;
          rd_idx   = 0;
        end
        if (rd_idx >= n_loaded) begin
          r.status = STATUS_EMPTY;
        end else begin
          d = longint'(trace_mem[rd_idx[ADDR_W-1:0]]) - mean_m;
          v = 0;
          if (peak_p != 0) begin
            // restoring division, FRAC_BITS fraction bits, then a round bit
            mag = (d < 0) ? -d : d;
            q   = (mag >= peak_p) ? 1 : 0;
            rem = mag - q * peak_p;
            if (rem >= peak_p) rem = rem % peak_p;
            for (int i = 0; i < FRAC_BITS; i++) begin
              rem = rem << 1;
              q   = q << 1;
              if (rem >= peak_p) begin
                rem = rem - peak_p;
                q   = q | 1;
              end
            end
            rem = rem << 1;
            if (rem >= peak_p) q = q + 1;
            if (d < 0) v = (q > 32768) ? -32768 : -q;
            else       v = (q > 32767) ? 32767 : q;
          end
          r.norm    = v[NORM_W-1:0];
          r.is_last = (rd_idx + 1 == n_loaded);
          rd_idx++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  // Random idle cycles between commands, start low while idling.
  task automatic idle_gap();
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
  endtask

  // Drives one command, holds it until the transfer, then records what the
  // model expects back. A typed row overrides the model's expectation.
  task automatic send_cmd(input logic f, input logic signed [SMP_W-1:0] s,
                          input bit typed, input norm_result_t typed_r);
    bit           produced;
    norm_result_t r;
    start     <= 1'b1;
    func      <= f;
    sample_in <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    trace_model_step(f, s, produced, r);
    if (typed) r = typed_r;
    if (produced || typed) pending_results = {pending_results, r};
    idle_gap();
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic add_row(input logic f, input logic signed [SMP_W-1:0] s, input bit typed,
                         input logic signed [NORM_W-1:0] n, input logic l,
                         input logic [1:0] st);
    stim_row_t row;
    row.func           = f;
    row.sample         = s;
    row.typed          = typed;
    row.result.norm    = n;
    row.result.is_last = l;
    row.result.status  = st;
    directed_rows = {directed_rows, row};
  endtask

  // Random sample, style chosen per trace: full range, small, clustered,
  // constant or extreme values.
  function automatic logic signed [SMP_W-1:0] pick_sample(input int style,
                                                           input logic signed [SMP_W-1:0] base);
    logic signed [SMP_W-1:0] v;
    case (style)
      0:       v = $urandom;
      1:       v = int'($urandom_range(0, 2000)) - 1000;
      2:       v = base + int'($urandom_range(0, 7));
      3:       v = base;
      default: begin
        case ($urandom_range(4))
          0:       v = 32'sh7FFF_FFFF;
          1:       v = 32'sh8000_0000;
          2:       v = '0;
          3:       v = -1;
          default: v = $urandom;
        endcase
      end
    endcase
    return v;
  endfunction

  initial begin : stimulus
    norm_result_t            none_r;
    logic signed [SMP_W-1:0] base;
    int                      style, len, n_fetch, pick, items;
    int                      trace_no;

    none_r = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Typed rows: fetch after reset, full-scale pair,
    // fetch past the end, zero peak, single sample trace.
    add_row(FUNC_FETCH, 32'sd0,          1, 16'sd0,      1'b0, STATUS_EMPTY);
    add_row(FUNC_LOAD,  32'sh7FFF_FFFF,  0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_LOAD,  32'sh8000_0000,  0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sh7FFF_FFFF,  1, 16'sd32767,  1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sh8000_0000,  1, -16'sd32768, 1'b1, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          1, 16'sd0,      1'b0, STATUS_EMPTY);
    add_row(FUNC_FETCH, -32'sd1,         1, 16'sd0,      1'b0, STATUS_EMPTY);
    add_row(FUNC_LOAD,  32'sd5,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_LOAD,  32'sd5,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          1, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          1, 16'sd0,      1'b1, STATUS_OK);
    add_row(FUNC_LOAD,  -32'sd7,         0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          1, 16'sd0,      1'b1, STATUS_OK);
    add_row(FUNC_LOAD,  32'sd1,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_LOAD,  32'sd2,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_LOAD,  -32'sd1,         0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_LOAD,  -32'sd2,         0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_LOAD,  32'sd1234,       0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_LOAD,  32'sd0,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          0, 16'sd0,      1'b0, STATUS_OK);
    add_row(FUNC_FETCH, 32'sd0,          0, 16'sd0,      1'b0, STATUS_OK);
    foreach (directed_rows[i])
      send_cmd(directed_rows[i].func, directed_rows[i].sample,
               directed_rows[i].typed, directed_rows[i].result);
    drain_results();

    // Fill the whole store, overrun it by three, then read it all back
    // and once more past the end.
    for (int i = 0; i < DEPTH + 3; i++) begin
      if (i % 512 == 7) base = (i % 1024 == 7) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      else              base = $urandom;
      send_cmd(FUNC_LOAD, base, 0, none_r);
    end
    for (int i = 0; i < DEPTH + 1; i++) send_cmd(FUNC_FETCH, $urandom, 0, none_r);
    drain_results();

    // Random traces: mostly load-then-fetch runs, some overrunning or cut
    // short by a new load, plus a share of random commands.
    items    = 0;
    trace_no = 0;
    while (items < RANDOM_ITEMS) begin
      steady = (items >= 400 && items < 600);
      trace_no++;
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 6)) begin
          send_cmd(1'($urandom_range(1)), $urandom, 0, none_r);
          items++;
        end
      end else begin
        style = $urandom_range(4);
        base  = $urandom;
        len   = ($urandom_range(99) < 90) ? $urandom_range(1, 16) : $urandom_range(17, 64);
        for (int i = 0; i < len; i++) begin
          send_cmd(FUNC_LOAD, pick_sample(style, base), 0, none_r);
          items++;
        end
        pick = $urandom_range(99);
        if (pick < 70)      n_fetch = len;
        else if (pick < 85) n_fetch = len + $urandom_range(1, 2);
        else                n_fetch = $urandom_range(0, len - 1);
        for (int i = 0; i < n_fetch; i++) begin
          send_cmd(FUNC_FETCH, $urandom, 0, none_r);
          items++;
        end
      end
      if (trace_no % 40 == 0) drain_results();
    end
    steady = 1'b0;

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else                 $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Result side: every strobe is matched against the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    norm_result_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, exp none got norm %0d last %0b status %0d",
                 $time, norm_value, final_flag, status);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (norm_value !== exp_r.norm) begin
          $display("%0t: norm_value mismatch, exp %0d got %0d", $time, exp_r.norm, norm_value);
          fail_count++;
        end
        if (final_flag !== exp_r.is_last) begin
          $display("%0t: final_flag mismatch, exp %0b got %0b",
                   $time, exp_r.is_last, final_flag);
          fail_count++;
        end
        if (status !== exp_r.status) begin
          $display("%0t: status mismatch, exp %0d got %0d", $time, exp_r.status, status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired, %0d results outstanding",
                 $time, pending_results.size());
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

endmodule

[dc_removal_peak_normalizer.f]
rtl/core/dcpn_pkg.sv
rtl/core/dcpn_divider.sv
rtl/core/dcpn_trace_store.sv
rtl/core/dc_removal_peak_normalizer.sv
tb/tb_dc_removal_peak_normalizer.sv
